// ===== rtl/core/efd_pkg.sv =====
// Shared types and constants for the error diffusion dither block.
`default_nettype none

package efd_pkg;

  localparam int PIX_W      = 8;
  localparam int NUM_LANES  = 3;
  localparam int FW_W       = 12;
  localparam int FH_W       = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [FW_W-1:0] FW_RESET = 12'd640;
  localparam logic [FH_W-1:0] FH_RESET = 16'd480;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } pix_t;

  typedef struct packed {
    logic red_on;
    logic green_on;
    logic blue_on;
    logic frame_end;
  } res_t;

  // position flags of one pixel, shared by all lanes
  typedef struct packed {
    logic first_row;
    logic col_nz;
    logic last_col;
    logic last_row;
  } ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/efd_stream_if.sv =====
// Valid/ready stream channel carrying one payload word.
`default_nettype none

interface efd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/efd_lane.sv =====
// One color channel of the Floyd-Steinberg datapath with its carry registers.
`default_nettype none

module efd_lane #(
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire efd_pkg::ctl_t                   ctl_i,
  input  wire logic [efd_pkg::PIX_W-1:0]       pix_i,
  input  wire logic signed [PIXEL_BITS+5:0]    nre_i,
  output logic                                 on_o,
  output logic signed [PIXEL_BITS+5:0]         diag_o,
  output logic signed [PIXEL_BITS+5:0]         nd_o
);
  import efd_pkg::*;

  localparam int CH    = PIXEL_BITS + 6;
  localparam int ACC_W = CH + 3;
  localparam int FULL  = ((1 << PIXEL_BITS) - 1) * 16;
  localparam int HALF  = FULL / 2;

  localparam logic signed [ACC_W-1:0] FULL_S = ACC_W'(FULL);
  localparam logic signed [ACC_W-1:0] HALF_S = ACC_W'(HALF);
  localparam logic signed [ACC_W-1:0] MAX_S  = ACC_W'((1 << (CH - 1)) - 1);
  localparam logic signed [ACC_W-1:0] MIN_S  = -ACC_W'(1 << (CH - 1));
  // signed zero keeps the shift arms of the selects arithmetic
  localparam logic signed [ACC_W-1:0] ZERO_S = '0;

  function automatic logic signed [CH-1:0] sat(input logic signed [ACC_W-1:0] x);
    logic signed [CH-1:0] r;
    if (x > MAX_S)      r = MAX_S[CH-1:0];
    else if (x < MIN_S) r = MIN_S[CH-1:0];
    else                r = x[CH-1:0];
    return r;
  endfunction

  logic signed [CH-1:0]    rc_q, rc_d, dc_q, dc_d;
  logic [PIXEL_BITS-1:0]   v;
  logic signed [ACC_W-1:0] vx, nrex, rcx, r7, r7s, ax, ex, e3, e5, rcs;
  logic signed [CH-1:0]    acc, e;

  always_comb begin
    v    = PIXEL_BITS'(pix_i);
    vx   = $signed(ACC_W'({v, 4'b0000}));
    nrex = ctl_i.first_row ? '0 : ACC_W'(nre_i);
    rcx  = ACC_W'(rc_q);
    r7   = (rcx <<< 3) - rcx;
    r7s  = ctl_i.col_nz ? (r7 >>> 4) : ZERO_S;
    acc  = sat(vx + nrex + r7s);
    ax   = ACC_W'(acc);
    on_o = ax > HALF_S;
    e    = sat(ax - (on_o ? FULL_S : '0));
    ex   = ACC_W'(e);
    e3   = (ex <<< 1) + ex;
    e5   = (ex <<< 2) + ex;
    diag_o = sat(ACC_W'(dc_q) + (e3 >>> 4));
    rcs  = ctl_i.col_nz ? (rcx >>> 4) : ZERO_S;
    nd_o = sat(rcs + (e5 >>> 4));
    rc_d = rc_q;
    dc_d = dc_q;
    if (en_i) begin
      rc_d = ctl_i.last_col ? '0 : e;
      dc_d = ctl_i.last_col ? '0 : nd_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q <= '0;
      dc_q <= '0;
    end else begin
      rc_q <= rc_d;
      dc_q <= dc_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/efd_linebuf.sv =====
// Next-row error line buffer: RAM with one read and one write port, one pending write, read bypass.
`default_nettype none

module efd_linebuf #(
  parameter int DEPTH  = 2048,
  parameter int DATA_W = 42
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]             rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0]        wr_data_i,
  input  wire logic                     pend_set_i,
  input  wire logic [$clog2(DEPTH)-1:0] pend_addr_i,
  input  wire logic [DATA_W-1:0]        pend_data_i
);
  localparam int AW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q, byp_q, byp_d, pend_data_q;
  logic [AW-1:0]     pend_addr_q;
  logic              pend_vld_q, pend_vld_d, byp_sel_q, byp_sel_d, commit;

  // the parked write drains on any cycle the direct write leaves free
  assign commit = pend_vld_q && !wr_en_i;

  always_comb begin
    pend_vld_d = pend_vld_q;
    if (pend_set_i)  pend_vld_d = 1'b1;
    else if (commit) pend_vld_d = 1'b0;
    // newest write to the read address wins
    byp_sel_d = 1'b1;
    byp_d     = pend_data_q;
    if (wr_en_i && wr_addr_i == rd_addr_i)            byp_d = wr_data_i;
    else if (pend_set_i && pend_addr_i == rd_addr_i)  byp_d = pend_data_i;
    else if (pend_vld_q && pend_addr_q == rd_addr_i)  byp_d = pend_data_q;
    else                                              byp_sel_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i)     mem[wr_addr_i]   <= wr_data_i;
    else if (commit) mem[pend_addr_q] <= pend_data_q;
    if (rd_en_i) begin
      rd_q  <= mem[rd_addr_i];
      byp_q <= byp_d;
    end
    if (pend_set_i) begin
      pend_addr_q <= pend_addr_i;
      pend_data_q <= pend_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      byp_sel_q  <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      if (rd_en_i) byp_sel_q <= byp_sel_d;
    end
  end

  assign rd_data_o = byp_sel_q ? byp_q : rd_q;

endmodule

`default_nettype wire

// ===== rtl/core/error_diffusion_dither.sv =====
// Top level: Floyd-Steinberg RGB binarizer with three channel lanes.
//
//   channel  dir  word                                   accepted when
//   pix_i    in   red_in, green_in, blue_in (8b each)    valid && ready
//   res_o    out  red_on, green_on, blue_on, frame_end   valid && ready
//   cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i        cfg_we_i high
//
// One pixel per clock sustained while res_o.ready stays high; an accepted
// pixel passes the compute stage, then the output register. The loop that
// sets the rate is the right-carry feedback inside each lane.
// Reset clears position, carries and handshake state; the line buffer is not
// cleared, the first row of every frame ignores it.
// A stalled result holds the compute stage; input ready drops only when both
// the compute stage and the output register are full.
`default_nettype none

module error_diffusion_dither #(
  parameter int MAX_WIDTH  = 2048,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  efd_stream_if.sink                              pix_i,
  efd_stream_if.source                            res_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [efd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [efd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import efd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int CH = PIXEL_BITS + 6;
  localparam int EW = NUM_LANES * CH;

  // configuration
  logic [FW_W-1:0] fw_q;
  logic [FH_W-1:0] fh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FW_RESET;
      fh_q <= FH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_q <= FW_W'(cfg_data_i);
        CFG_FRAME_HEIGHT: fh_q <= FH_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // last column / row index after clamping the programmed size
  logic [CW-1:0]   wm1;
  logic [FH_W-1:0] hm1;

  always_comb begin
    if (fw_q == '0)                  wm1 = '0;
    else if (32'(fw_q) > MAX_WIDTH)  wm1 = CW'(MAX_WIDTH - 1);
    else                             wm1 = CW'(fw_q - 12'd1);
    hm1 = (fh_q == '0) ? '0 : fh_q - 16'd1;
  end

  // handshake and position
  logic          s1_vld_q, s1_vld_d, out_vld_q, out_vld_d;
  logic          out_free, s1_adv, accept;
  logic [CW-1:0] col_q, col_d, s1_col_q;
  logic [FH_W-1:0] row_q, row_d;
  ctl_t          ctl_in, s1_ctl_q;
  pix_t          s1_pix_q;
  res_t          out_q;

  assign out_free    = !out_vld_q || res_o.ready;
  assign s1_adv      = s1_vld_q && out_free;
  assign pix_i.ready = !s1_vld_q || s1_adv;
  assign accept      = pix_i.valid && pix_i.ready;

  always_comb begin
    ctl_in.first_row = row_q == '0;
    ctl_in.col_nz    = col_q != '0;
    ctl_in.last_col  = col_q >= wm1;
    ctl_in.last_row  = row_q >= hm1;
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (ctl_in.last_col) begin
        col_d = '0;
        row_d = ctl_in.last_row ? '0 : row_q + 16'd1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
    s1_vld_d  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_q);
    out_vld_d = s1_adv ? 1'b1 : (res_o.ready ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q <= pix_i.payload;
      s1_ctl_q <= ctl_in;
      s1_col_q <= col_q;
    end
  end

  // lanes: red is lane 0
  logic [NUM_LANES-1:0][PIX_W-1:0] lane_pix;
  logic [EW-1:0]                   nre_word, diag_word, nd_word;
  logic [NUM_LANES-1:0]            lane_on;

  assign lane_pix[0] = s1_pix_q.red_in;
  assign lane_pix[1] = s1_pix_q.green_in;
  assign lane_pix[2] = s1_pix_q.blue_in;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    efd_lane #(
      .PIXEL_BITS (PIXEL_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (s1_adv),
      .ctl_i  (s1_ctl_q),
      .pix_i  (lane_pix[g]),
      .nre_i  ($signed(nre_word[g*CH +: CH])),
      .on_o   (lane_on[g]),
      .diag_o (diag_word[g*CH +: CH]),
      .nd_o   (nd_word[g*CH +: CH])
    );
  end

  // line buffer writes: below-left entry each column, own entry at row end
  logic          lb_wr_en, lb_pend_set;
  logic [CW-1:0] lb_wr_addr;
  logic [EW-1:0] lb_wr_data;

  always_comb begin
    lb_wr_en    = s1_adv && (s1_ctl_q.col_nz || s1_ctl_q.last_col);
    lb_wr_addr  = s1_ctl_q.col_nz ? CW'(s1_col_q - 1'b1) : s1_col_q;
    lb_wr_data  = s1_ctl_q.col_nz ? diag_word : nd_word;
    lb_pend_set = s1_adv && s1_ctl_q.col_nz && s1_ctl_q.last_col;
  end

  efd_linebuf #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (EW)
  ) u_linebuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr_i   (col_q),
    .rd_data_o   (nre_word),
    .wr_en_i     (lb_wr_en),
    .wr_addr_i   (lb_wr_addr),
    .wr_data_i   (lb_wr_data),
    .pend_set_i  (lb_pend_set),
    .pend_addr_i (s1_col_q),
    .pend_data_i (nd_word)
  );

  // merge lanes into the result word
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.red_on    <= lane_on[0];
      out_q.green_on  <= lane_on[1];
      out_q.blue_on   <= lane_on[2];
      out_q.frame_end <= s1_ctl_q.last_col && s1_ctl_q.last_row;
    end
  end

  assign res_o.valid   = out_vld_q;
  assign res_o.payload = out_q;

  // never load the compute stage while it still holds a word
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !s1_adv |-> !s1_vld_q)
    else $error("compute stage overrun");

  // a held compute word stays until the output register frees up
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !out_free |=> s1_vld_q)
    else $error("compute word dropped under stall");

  // frame wrap: last pixel of a frame returns position to the origin
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && ctl_in.last_col && ctl_in.last_row |=> col_q == '0 && row_q == '0)
    else $error("position not wrapped at frame end");

endmodule

`default_nettype wire
